// ===== design/imusfd_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder package
// Shared constants, scale types and the scale selection function.
// ----------------------------------------------------------------------------
package imusfd_pkg;

  // Frame bytes.
  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC = 8'h51;
  localparam logic [7:0] TYPE_GYR = 8'h52;
  localparam logic [7:0] TYPE_EUL = 8'h53;

  // Frame position counter values.
  localparam logic [3:0] POS_HUNT  = 4'd0;
  localparam logic [3:0] POS_TYPE  = 4'd1;
  localparam logic [3:0] POS_CHECK = 4'd10;

  // Result kinds.
  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_GYR = 2'd1;
  localparam logic [1:0] KIND_EUL = 2'd2;

  // Every linear value is floor((|r| * mul + ofs) / 2^25), which covers the
  // acceleration scale (division by 625, rounded), the angular rate scale and
  // the exact degree scale with one multiply-add.
  localparam int VAL_SHIFT = 25;
  localparam int MUL_W     = 34;
  localparam int OFS_W     = 25;
  localparam int PROD_W    = 49;
  localparam int MAG_W     = 24;

  localparam logic [MUL_W-1:0] MUL_ACC = 34'd10529810259;
  localparam logic [OFS_W-1:0] OFS_ACC = 25'd16750373;
  localparam logic [MUL_W-1:0] MUL_GYR = 34'd2342541312;
  localparam logic [OFS_W-1:0] OFS_GYR = 25'd16777216;
  localparam logic [MUL_W-1:0] MUL_EUL = 34'd12079595520;
  localparam logic [OFS_W-1:0] OFS_EUL = 25'd0;

  // Radians: floor((|r| * 411775 + 2^15) / 2^16).
  localparam int RAD_SHIFT = 16;
  localparam int RAD_PROD_W = 34;
  localparam int RAD_MAG_W  = 18;
  localparam logic [18:0] RAD_MUL = 19'd411775;
  localparam logic [15:0] RAD_OFS = 16'd32768;

  typedef struct packed {
    logic [MUL_W-1:0] mul;
    logic [OFS_W-1:0] ofs;
  } scale_t;

  function automatic scale_t scale_for(input logic [7:0] type_code);
    scale_t s;
    case (type_code)
      TYPE_ACC: s = '{mul: MUL_ACC, ofs: OFS_ACC};
      TYPE_GYR: s = '{mul: MUL_GYR, ofs: OFS_GYR};
      TYPE_EUL: s = '{mul: MUL_EUL, ofs: OFS_EUL};
      default:  s = '{mul: '0, ofs: '0};
    endcase
    return s;
  endfunction

endpackage

// ===== design/imusfd_byte_if.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder byte channel
// Valid/ready channel that carries one received serial byte.
// ----------------------------------------------------------------------------
interface imusfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/imusfd_sample_if.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder sample channel
// Valid/ready channel that carries one decoded sensor sample.
// ----------------------------------------------------------------------------
interface imusfd_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [24:0] x_value;
  logic signed [24:0] y_value;
  logic signed [24:0] z_value;
  logic signed [18:0] roll_radians;
  logic signed [18:0] pitch_radians;
  logic signed [18:0] yaw_radians;
  logic [31:0]        sequence_res;

  modport source (output valid, output kind, output x_value, output y_value,
                  output z_value, output roll_radians, output pitch_radians,
                  output yaw_radians, output sequence_res, input ready);
  modport sink (input valid, input kind, input x_value, input y_value,
                input z_value, input roll_radians, input pitch_radians,
                input yaw_radians, input sequence_res, output ready);
endinterface

// ===== design/imusfd_axis_conv.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder axis converter
// Scales one raw signed 16-bit word into its Q8.16 value and Q2.16 radians.
// ----------------------------------------------------------------------------
module imusfd_axis_conv (
  input  logic                   clk,
  input  logic signed [15:0]     word,
  input  imusfd_pkg::scale_t     scale,
  output logic signed [24:0]     value,
  output logic signed [18:0]     radians
);

  logic [15:0]                          mag;
  logic                                 neg;
  logic [imusfd_pkg::PROD_W-1:0]        prod;
  logic [imusfd_pkg::RAD_PROD_W-1:0]    rad_prod;
  logic [24:0]                          val_mag;
  logic [18:0]                          rad_mag;

  // Magnitude of the word; the most negative word maps to 32768 unsigned.
  always_comb begin
    mag = word[15] ? (~word + 16'd1) : word;
  end

  // Multiply-add stage, rounding offset included.
  always_ff @(posedge clk) begin
    neg      <= word[15];
    prod     <= imusfd_pkg::PROD_W'(mag) * imusfd_pkg::PROD_W'(scale.mul)
              + imusfd_pkg::PROD_W'(scale.ofs);
    rad_prod <= imusfd_pkg::RAD_PROD_W'(mag) * imusfd_pkg::RAD_PROD_W'(imusfd_pkg::RAD_MUL)
              + imusfd_pkg::RAD_PROD_W'(imusfd_pkg::RAD_OFS);
  end

  // Drop the fraction and restore the sign.
  always_comb begin
    val_mag = {1'b0, prod[imusfd_pkg::VAL_SHIFT +: imusfd_pkg::MAG_W]};
    rad_mag = {1'b0, rad_prod[imusfd_pkg::RAD_SHIFT +: imusfd_pkg::RAD_MAG_W]};
    value   = neg ? $signed(~val_mag + 25'd1) : $signed(val_mag);
    radians = neg ? $signed(~rad_mag + 19'd1) : $signed(rad_mag);
  end

endmodule

// ===== design/imu_serial_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame decoder
// Parses 11-byte inertial sensor frames into scaled fixed-point samples.
// ----------------------------------------------------------------------------
// Usage:
// The byte_in channel takes one received serial byte per transaction. The
// decoder hunts for the header byte 0x55, then collects a type byte, three
// little-endian signed words, two further bytes and a checksum byte. The
// checksum is kept as a running 8-bit sum, so no frame is buffered whole.
// When the checksum matches and the type is acceleration, angular rate or
// Euler angles, one sample transaction is offered on sample_out; frames with
// a bad checksum or an unknown type are dropped without a trace.
// Throughput is one byte per cycle. The sample appears in the cycle after the
// checksum byte is accepted. Each axis word is scaled by a registered
// multiply-add fed from the stored words; the checksum byte arrives at least
// three transactions after the last axis word byte, so the products are
// always settled when the sample is formed.
// The result sits in an output register. While it waits, bytes keep being
// accepted; only the checksum byte of the next frame is held back (ready
// low) until the previous sample has been taken.
// Reset clears the frame position, the sample count and the output valid.
// The first sample reports a sequence count of one; the count wraps at 2^32.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top (
  input  logic             clk,
  input  logic             rst,
  imusfd_byte_if.sink      byte_in,
  imusfd_sample_if.source  sample_out
);

  // Frame tracking state.
  logic [3:0]  pos;
  logic [7:0]  sum;
  logic [7:0]  type_byte;
  logic [15:0] x_word;
  logic [15:0] y_word;
  logic [15:0] z_word;

  // Output register.
  logic               out_valid;
  logic [1:0]         kind;
  logic signed [24:0] x_value;
  logic signed [24:0] y_value;
  logic signed [24:0] z_value;
  logic signed [18:0] roll_radians;
  logic signed [18:0] pitch_radians;
  logic signed [18:0] yaw_radians;
  logic [31:0]        sample_count;
  logic [31:0]        sample_count_next;

  logic               byte_take;
  logic               emit;
  logic               known;
  logic [1:0]         kind_next;
  logic [7:0]         rx;
  imusfd_pkg::scale_t scale;

  logic signed [24:0] x_conv;
  logic signed [24:0] y_conv;
  logic signed [24:0] z_conv;
  logic signed [18:0] x_rad;
  logic signed [18:0] y_rad;
  logic signed [18:0] z_rad;

  assign rx = byte_in.rx_byte;

  // Only the checksum byte can create a sample, so only it waits for room.
  assign byte_in.ready = (pos != imusfd_pkg::POS_CHECK) || !out_valid || sample_out.ready;
  assign byte_take     = byte_in.valid && byte_in.ready;

  // Decode the stored type byte into a result kind.
  always_comb begin
    known     = 1'b1;
    kind_next = imusfd_pkg::KIND_ACC;
    unique case (type_byte)
      imusfd_pkg::TYPE_ACC: kind_next = imusfd_pkg::KIND_ACC;
      imusfd_pkg::TYPE_GYR: kind_next = imusfd_pkg::KIND_GYR;
      imusfd_pkg::TYPE_EUL: kind_next = imusfd_pkg::KIND_EUL;
      default:              known     = 1'b0;
    endcase
  end

  assign scale = imusfd_pkg::scale_for(type_byte);

  assign emit = byte_take && (pos == imusfd_pkg::POS_CHECK) && (sum == rx) && known;
  assign sample_count_next = sample_count + 32'd1;

  // Per-axis scaling units.
  imusfd_axis_conv u_conv_x (
    .clk     (clk),
    .word    ($signed(x_word)),
    .scale   (scale),
    .value   (x_conv),
    .radians (x_rad)
  );

  imusfd_axis_conv u_conv_y (
    .clk     (clk),
    .word    ($signed(y_word)),
    .scale   (scale),
    .value   (y_conv),
    .radians (y_rad)
  );

  imusfd_axis_conv u_conv_z (
    .clk     (clk),
    .word    ($signed(z_word)),
    .scale   (scale),
    .value   (z_conv),
    .radians (z_rad)
  );

  // Control state: frame position, running checksum, count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= imusfd_pkg::POS_HUNT;
      sum          <= 8'd0;
      sample_count <= 32'd0;
      out_valid    <= 1'b0;
    end else begin
      if (byte_take) begin
        case (pos) inside
          [4'd1:4'd9]: begin
            sum <= sum + rx;
            pos <= pos + 4'd1;
          end
          imusfd_pkg::POS_CHECK: begin
            pos <= imusfd_pkg::POS_HUNT;
          end
          default: begin
            // Hunting, or an out-of-range position treated as hunting.
            if (rx == imusfd_pkg::HDR_BYTE) begin
              pos <= imusfd_pkg::POS_TYPE;
              sum <= imusfd_pkg::HDR_BYTE;
            end else begin
              pos <= imusfd_pkg::POS_HUNT;
            end
          end
        endcase
      end
      if (emit) begin
        out_valid    <= 1'b1;
        sample_count <= sample_count_next;
      end else if (sample_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame contents and output payload.
  always_ff @(posedge clk) begin
    if (byte_take) begin
      case (pos)
        imusfd_pkg::POS_TYPE: type_byte   <= rx;
        4'd2:                 x_word[7:0]  <= rx;
        4'd3:                 x_word[15:8] <= rx;
        4'd4:                 y_word[7:0]  <= rx;
        4'd5:                 y_word[15:8] <= rx;
        4'd6:                 z_word[7:0]  <= rx;
        4'd7:                 z_word[15:8] <= rx;
        default: ;
      endcase
    end
    if (emit) begin
      kind    <= kind_next;
      x_value <= x_conv;
      y_value <= y_conv;
      z_value <= z_conv;
      if (kind_next == imusfd_pkg::KIND_EUL) begin
        roll_radians  <= x_rad;
        pitch_radians <= y_rad;
        yaw_radians   <= z_rad;
      end else begin
        roll_radians  <= '0;
        pitch_radians <= '0;
        yaw_radians   <= '0;
      end
    end
  end

  assign sample_out.valid         = out_valid;
  assign sample_out.kind          = kind;
  assign sample_out.x_value       = x_value;
  assign sample_out.y_value       = y_value;
  assign sample_out.z_value       = z_value;
  assign sample_out.roll_radians  = roll_radians;
  assign sample_out.pitch_radians = pitch_radians;
  assign sample_out.yaw_radians   = yaw_radians;
  assign sample_out.sequence_res  = sample_count;

endmodule

// ===== design/imusfd_checker.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder checker
// Port-level assertions on the decoder's channels, bound to the top level.
// ----------------------------------------------------------------------------
module imusfd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic signed [18:0] roll_radians,
  input logic signed [18:0] pitch_radians,
  input logic signed [18:0] yaw_radians,
  input logic [31:0]        sequence_res
);

  // A stalled sample stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("sample dropped while stalled");

  // A new sample can only follow an accepted byte.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("sample appeared without an accepted byte");

  // A sample offered right after a taken one is new and counts up by one.
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) ##1 out_valid |-> sequence_res == $past(sequence_res) + 32'd1)
    else $error("sequence count did not advance by one");

  // Radians are only reported for Euler samples.
  a_rad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != imusfd_pkg::KIND_EUL) |->
      (roll_radians == '0) && (pitch_radians == '0) && (yaw_radians == '0))
    else $error("radians nonzero on a non-Euler sample");

endmodule

bind imu_serial_frame_decoder_top imusfd_checker u_imusfd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_in.valid),
  .in_ready      (byte_in.ready),
  .out_valid     (sample_out.valid),
  .out_ready     (sample_out.ready),
  .kind          (sample_out.kind),
  .roll_radians  (sample_out.roll_radians),
  .pitch_radians (sample_out.pitch_radians),
  .yaw_radians   (sample_out.yaw_radians),
  .sequence_res  (sample_out.sequence_res)
);

// ===== sim/tb_imu_serial_frame_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU serial frame decoder testbench
// Feeds serial bytes into the decoder and checks every sample that comes out
// against a behavioral copy of the frame parser and its fixed-point scaling.
// ----------------------------------------------------------------------------
module tb_imu_serial_frame_decoder_top;

  // One decoded sample, laid out field by field as on the sample channel.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [24:0] x_value;
    logic signed [24:0] y_value;
    logic signed [24:0] z_value;
    logic signed [18:0] roll_radians;
    logic signed [18:0] pitch_radians;
    logic signed [18:0] yaw_radians;
    logic [31:0]        sequence_res;
  } sample_t;

  // One row of the directed table: optional filler bytes ahead of the
  // frame, the frame contents, an offset that corrupts the checksum, and
  // an expected sample where it is obvious enough to write by hand.
  typedef struct packed {
    logic [3:0]  lead_n;
    logic [7:0]  lead_byte;
    logic [7:0]  type_code;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [7:0]  t8;
    logic [7:0]  t9;
    logic [7:0]  sum_err;
    logic        typed;
    sample_t     want;
  } frame_row_t;

  localparam sample_t NO_SAMPLE = '0;

  // Scale factors of the three frame kinds, as exact integer ratios.
  localparam longint ACC_MUL = 196133;
  localparam longint ACC_DIV = 625;
  localparam longint GYR_MUL = 4575276;
  localparam longint RAD_MUL = 411775;
  localparam longint Q16_DIV = 65536;
  localparam longint DEG_MUL = 360;

  localparam int ITEM_TARGET  = 450;  // bytes before the random part stops
  localparam int HOLD_FRAME   = 8;    // random frame that starts the long hold
  localparam int DRAIN_FRAME  = 20;   // random frame ahead of which input pauses
  localparam int LONG_HOLD    = 400;  // cycles the sample side holds ready low
  localparam int STALL_LIMIT  = 2000; // cycles without any transaction
  localparam int TAIL_CYCLES  = 20;

  localparam int DIRECTED_ROWS = 13;

  // Directed frames. The first four start right after reset, so their
  // sequence numbers and the scaled extremes can be written out directly.
  localparam frame_row_t DIRECTED [DIRECTED_ROWS] = '{
    // All-zero acceleration frame: the first sample carries sequence one.
    '{4'd0, 8'h00, imusfd_pkg::TYPE_ACC, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00,
      8'h00, 1'b1, '{imusfd_pkg::KIND_ACC, 25'sd0, 25'sd0, 25'sd0,
                     19'sd0, 19'sd0, 19'sd0, 32'd1}},
    // Acceleration at both ends of the raw range, after two filler bytes.
    '{4'd2, 8'h00, imusfd_pkg::TYPE_ACC, 16'h7FFF, 16'h8000, 16'h0000, 8'h00, 8'h00,
      8'h00, 1'b1, '{imusfd_pkg::KIND_ACC, 25'sd10282704, -25'sd10283018, 25'sd0,
                     19'sd0, 19'sd0, 19'sd0, 32'd2}},
    // Angular rate extremes plus the smallest positive word.
    '{4'd1, 8'hFF, imusfd_pkg::TYPE_GYR, 16'h7FFF, 16'h8000, 16'h0001, 8'h00, 8'h00,
      8'h00, 1'b1, '{imusfd_pkg::KIND_GYR, 25'sd2287568, -25'sd2287638, 25'sd70,
                     19'sd0, 19'sd0, 19'sd0, 32'd3}},
    // Euler extremes; the negative radian value is an exact tie.
    '{4'd0, 8'h00, imusfd_pkg::TYPE_EUL, 16'h7FFF, 16'h8000, 16'h0000, 8'h00, 8'h00,
      8'h00, 1'b1, '{imusfd_pkg::KIND_EUL, 25'sd11796120, -25'sd11796480, 25'sd0,
                     19'sd205881, -19'sd205888, 19'sd0, 32'd4}},
    // Bad checksum: dropped.
    '{4'd0, 8'h00, imusfd_pkg::TYPE_EUL, 16'h1234, 16'hFEDC, 16'h0001, 8'h00, 8'h00,
      8'h01, 1'b0, NO_SAMPLE},
    // Unknown type codes, including the header value itself, are dropped.
    '{4'd0, 8'h00, 8'h00, 16'h0100, 16'h0200, 16'h0300, 8'h00, 8'h00, 8'h00,
      1'b0, NO_SAMPLE},
    // Header value inside the frame is plain data.
    '{4'd0, 8'h00, imusfd_pkg::TYPE_GYR, 16'h5555, 16'h0055, 16'h5500, 8'h55, 8'hFF,
      8'h00, 1'b0, NO_SAMPLE},
    '{4'd3, 8'hAA, imusfd_pkg::TYPE_ACC, 16'hFFFF, 16'h0001, 16'h8001, 8'h12, 8'h34,
      8'h00, 1'b0, NO_SAMPLE},
    '{4'd0, 8'h00, imusfd_pkg::HDR_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00,
      8'h00, 1'b0, NO_SAMPLE},
    '{4'd0, 8'h00, imusfd_pkg::TYPE_EUL, 16'hFFFF, 16'h0001, 16'h7FFF, 8'hFF, 8'h00,
      8'h00, 1'b0, NO_SAMPLE},
    '{4'd0, 8'h00, imusfd_pkg::TYPE_GYR, 16'hFFFF, 16'h0000, 16'h8001, 8'h00, 8'h00,
      8'h80, 1'b0, NO_SAMPLE},
    '{4'd0, 8'h00, imusfd_pkg::TYPE_ACC, 16'h0100, 16'hFF00, 16'h00FF, 8'hAA, 8'h55,
      8'h00, 1'b0, NO_SAMPLE},
    '{4'd0, 8'h00, 8'hFF, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 8'hFF, 8'h00,
      1'b0, NO_SAMPLE}
  };

  logic clk;
  logic rst;

  imusfd_byte_if   byte_if ();
  imusfd_sample_if sample_if ();

  imu_serial_frame_decoder_top u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .sample_out (sample_if)
  );

  // Parser state of the behavioral decoder.
  logic [3:0]  dec_pos;
  logic [7:0]  dec_frame [10];
  logic [31:0] dec_count;

  // Samples predicted but not yet seen on the output, oldest first.
  sample_t pending_samples [$];

  int  bytes_sent;
  int  samples_expected;
  int  error_count;
  int  stall_cycles;
  bit  src_idle_en;
  bit  snk_idle_en;
  bit  long_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic longint round_near(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // Advances the behavioral parser by one byte. Returns 1 when the byte
  // completes a valid frame of a known kind, with the sample in s.
  function automatic bit decode_byte(input logic [7:0] b, output sample_t s);
    logic [7:0]         sum;
    logic signed [15:0] word;
    longint             raw;
    longint             lin [3];
    longint             ang [3];
    s = NO_SAMPLE;
    if (dec_pos == imusfd_pkg::POS_HUNT || dec_pos > imusfd_pkg::POS_CHECK) begin
      dec_pos = imusfd_pkg::POS_HUNT;
      if (b == imusfd_pkg::HDR_BYTE) begin
        dec_frame[0] = imusfd_pkg::HDR_BYTE;
        dec_pos = imusfd_pkg::POS_TYPE;
      end
      return 1'b0;
    end
    if (dec_pos < imusfd_pkg::POS_CHECK) begin
      dec_frame[dec_pos] = b;
      dec_pos = dec_pos + 4'd1;
      return 1'b0;
    end
    // This byte is the checksum; the parser hunts again whatever happens.
    dec_pos = imusfd_pkg::POS_HUNT;
    sum = 8'h00;
    for (int i = 0; i < 10; i++) sum += dec_frame[i];
    if (sum != b) return 1'b0;
    for (int a = 0; a < 3; a++) begin
      word = $signed({dec_frame[3 + 2 * a], dec_frame[2 + 2 * a]});
      raw = longint'(word);
      ang[a] = 0;
      case (dec_frame[1])
        imusfd_pkg::TYPE_ACC: lin[a] = round_near(raw * ACC_MUL, ACC_DIV);
        imusfd_pkg::TYPE_GYR: lin[a] = round_near(raw * GYR_MUL, Q16_DIV);
        imusfd_pkg::TYPE_EUL: begin
          lin[a] = raw * DEG_MUL;
          ang[a] = round_near(raw * RAD_MUL, Q16_DIV);
        end
        default: return 1'b0;
      endcase
    end
    case (dec_frame[1])
      imusfd_pkg::TYPE_ACC: s.kind = imusfd_pkg::KIND_ACC;
      imusfd_pkg::TYPE_GYR: s.kind = imusfd_pkg::KIND_GYR;
      default:              s.kind = imusfd_pkg::KIND_EUL;
    endcase
    s.x_value       = lin[0][24:0];
    s.y_value       = lin[1][24:0];
    s.z_value       = lin[2][24:0];
    s.roll_radians  = ang[0][18:0];
    s.pitch_radians = ang[1][18:0];
    s.yaw_radians   = ang[2][18:0];
    dec_count       = dec_count + 32'd1;
    s.sequence_res  = dec_count;
    return 1'b1;
  endfunction

  // Offers one byte and waits for its transaction. It must be entered in
  // the time step of a rising edge. Valid stays high afterwards, so a
  // following byte with no gap goes out back to back without valid being
  // lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input sample_t typed_want = NO_SAMPLE);
    int unsigned gap;
    sample_t     s;
    gap = src_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    do @(posedge clk); while (!(byte_if.valid && byte_if.ready));
    bytes_sent++;
    if (decode_byte(b, s)) begin
      pending_samples.push_back(typed ? typed_want : s);
      samples_expected++;
    end
  endtask

  // Builds and sends a complete frame; sum_err is added to the correct checksum.
  task automatic send_frame(input logic [7:0] type_code,
                            input logic [15:0] w0, input logic [15:0] w1,
                            input logic [15:0] w2, input logic [7:0] t8,
                            input logic [7:0] t9, input logic [7:0] sum_err,
                            input bit typed = 1'b0,
                            input sample_t typed_want = NO_SAMPLE);
    logic [7:0] body [10];
    logic [7:0] sum;
    body = '{imusfd_pkg::HDR_BYTE, type_code, w0[7:0], w0[15:8], w1[7:0], w1[15:8],
             w2[7:0], w2[15:8], t8, t9};
    sum = sum_err;
    foreach (body[i]) sum += body[i];
    foreach (body[i]) send_byte(body[i], typed, typed_want);
    send_byte(sum, typed, typed_want);
  endtask

  // Raw words lean toward the ends of the range and the values around zero.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] known_type();
    case ($urandom_range(0, 2))
      0:       return imusfd_pkg::TYPE_ACC;
      1:       return imusfd_pkg::TYPE_GYR;
      default: return imusfd_pkg::TYPE_EUL;
    endcase
  endfunction

  // Compares one sample transaction with the oldest prediction.
  task automatic check_sample();
    sample_t got;
    sample_t want;
    got = '{sample_if.kind, sample_if.x_value, sample_if.y_value,
            sample_if.z_value, sample_if.roll_radians, sample_if.pitch_radians,
            sample_if.yaw_radians, sample_if.sequence_res};
    if (pending_samples.size() == 0) begin
      report_error($sformatf("unexpected sample, sequence %0d", got.sequence_res));
      return;
    end
    want = pending_samples.pop_front();
    if (got.kind !== want.kind)
      report_error($sformatf("seq %0d kind: got %0d, want %0d",
                             want.sequence_res, got.kind, want.kind));
    if (got.x_value !== want.x_value)
      report_error($sformatf("seq %0d x_value: got %0d, want %0d",
                             want.sequence_res, got.x_value, want.x_value));
    if (got.y_value !== want.y_value)
      report_error($sformatf("seq %0d y_value: got %0d, want %0d",
                             want.sequence_res, got.y_value, want.y_value));
    if (got.z_value !== want.z_value)
      report_error($sformatf("seq %0d z_value: got %0d, want %0d",
                             want.sequence_res, got.z_value, want.z_value));
    if (got.roll_radians !== want.roll_radians)
      report_error($sformatf("seq %0d roll_radians: got %0d, want %0d",
                             want.sequence_res, got.roll_radians, want.roll_radians));
    if (got.pitch_radians !== want.pitch_radians)
      report_error($sformatf("seq %0d pitch_radians: got %0d, want %0d",
                             want.sequence_res, got.pitch_radians, want.pitch_radians));
    if (got.yaw_radians !== want.yaw_radians)
      report_error($sformatf("seq %0d yaw_radians: got %0d, want %0d",
                             want.sequence_res, got.yaw_radians, want.yaw_radians));
    if (got.sequence_res !== want.sequence_res)
      report_error($sformatf("sequence_res: got %0d, want %0d",
                             got.sequence_res, want.sequence_res));
  endtask

  // Every sample transaction is checked at the edge that completes it.
  always @(posedge clk) begin
    if (!rst && sample_if.valid && sample_if.ready) check_sample();
  end

  // Watchdog: a run that makes no progress on either channel for too long
  // is a hang, whether the decoder lost a sample or stopped taking bytes.
  always @(posedge clk) begin
    if (rst || (byte_if.valid && byte_if.ready) || (sample_if.valid && sample_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sample side: ready drops for a random number of cycles before each
  // transaction, with stretches of no idling at all. Once during the run it
  // holds ready low for a long stretch so that the output register stays
  // full and the decoder has to hold back the next checksum byte.
  initial begin
    int unsigned gap;
    sample_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        sample_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 7) == 0) snk_idle_en = !snk_idle_en;
        gap = snk_idle_en ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
          sample_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      sample_if.ready <= 1'b1;
      do @(posedge clk); while (!(sample_if.valid && sample_if.ready));
    end
  end

  // Byte side: reset, the directed table, then random traffic that is
  // mostly well-formed frames with random contents, mixed with corrupted
  // checksums, unknown types, cut-off frames and loose noise bytes.
  initial begin
    frame_row_t  row;
    int          frame_no;
    int unsigned pick;
    logic [7:0]  odd_type;

    rst             <= 1'b1;
    byte_if.valid   <= 1'b0;
    byte_if.rx_byte <= 8'h00;
    dec_pos          = imusfd_pkg::POS_HUNT;
    dec_count        = 32'd0;
    foreach (dec_frame[i]) dec_frame[i] = 8'h00;
    bytes_sent       = 0;
    samples_expected = 0;
    error_count      = 0;
    src_idle_en      = 1'b1;
    snk_idle_en      = 1'b1;
    long_hold_req    = 1'b0;
    frame_no         = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames. Filler bytes ahead of a frame exercise hunting.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      repeat (row.lead_n) send_byte(row.lead_byte);
      send_frame(row.type_code, row.w0, row.w1, row.w2, row.t8, row.t9,
                 row.sum_err, row.typed, row.want);
    end

    while (bytes_sent < ITEM_TARGET) begin
      frame_no++;
      if (frame_no == HOLD_FRAME) long_hold_req = 1'b1;
      // Right after the long hold starts, bytes go out back to back so the
      // decoder really does fill up and stall its input.
      if (frame_no >= HOLD_FRAME && frame_no < HOLD_FRAME + 4) begin
        src_idle_en = 1'b0;
      end else begin
        src_idle_en = ($urandom_range(0, 3) != 0);
      end
      // Once, the byte side goes quiet until every sample has been taken.
      if (frame_no == DRAIN_FRAME) begin
        byte_if.valid <= 1'b0;
        do @(posedge clk); while (pending_samples.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        send_frame(known_type(), pick_word(), pick_word(), pick_word(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h00);
      end else if (pick < 86) begin
        send_frame(known_type(), pick_word(), pick_word(), pick_word(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(1, 255)));
      end else if (pick < 91) begin
        do odd_type = 8'($urandom_range(0, 255));
        while (odd_type == imusfd_pkg::TYPE_ACC || odd_type == imusfd_pkg::TYPE_GYR ||
               odd_type == imusfd_pkg::TYPE_EUL);
        send_frame(odd_type, pick_word(), pick_word(), pick_word(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h00);
      end else if (pick < 96) begin
        // A frame cut short: whatever follows is parsed as its remainder.
        send_byte(imusfd_pkg::HDR_BYTE);
        repeat ($urandom_range(1, 9)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    // Wind down: stop offering bytes, wait for the last samples, then give
    // the decoder a few more cycles to show any sample it should not send.
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
